// ===== rtl/ipv6p_pkg.sv =====
package ipv6p_pkg;

    // Address shape
    localparam int NumGroups  = 8;
    localparam int HeadKeep   = 4;   // only groups 0..3 reach the output
    localparam int MaxDigits  = 4;
    localparam int MaxLen     = 128;

    // Character codes
    localparam logic [7:0] CharNewline = 8'd10;
    localparam logic [7:0] CharColon   = 8'h3A;
    localparam logic [7:0] CharSlash   = 8'h2F;
    localparam logic [7:0] CharZero    = 8'h30;
    localparam logic [7:0] CharNine    = 8'h39;
    localparam logic [7:0] CharLowA    = 8'h61;
    localparam logic [7:0] CharLowF    = 8'h66;

    typedef logic [15:0] group_t;
    typedef logic [7:0]  char_t;
    typedef logic [3:0]  gcount_t;
    typedef logic [2:0]  dcount_t;

endpackage

// ===== rtl/ipv6_prefix_text_parser.sv =====
// Channel | Handshake             | Payload
// --------+-----------------------+--------------------------------------------
// in      | in_valid / in_stall   | char_code
// out     | out_valid / out_stall | prefix_upper, prefix_length, malformed
//
// One character is taken per cycle into an input register while in_stall is low.
// Any other character updates the parse state from it in the next cycle; a newline
// loads the result register and clears the parse state once the result register is free.
// in_stall rises only when a newline waits in the input register while the
// result register is still held by out_stall; other characters never stall.
// rst_n clears all parse state and both valid flags asynchronously.
module ipv6_prefix_text_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ipv6p_pkg::char_t     char_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [63:0]          prefix_upper,
    output logic [7:0]           prefix_length,
    output logic                 malformed
);
    import ipv6p_pkg::*;

    // Input register
    logic  in_valid_reg;
    char_t char_reg;

    // Parse state
    group_t  head_reg [HeadKeep];
    group_t  tail_reg [NumGroups];
    gcount_t head_count_reg;
    gcount_t tail_count_reg;
    logic    after_dc_reg;
    group_t  group_value_reg;
    dcount_t digit_count_reg;
    logic    last_colon_reg;
    logic    in_length_reg;
    logic [7:0] length_reg;
    logic    error_reg;

    // Next state
    group_t  head_next [HeadKeep];
    group_t  tail_next [NumGroups];
    gcount_t head_count_next;
    gcount_t tail_count_next;
    logic    after_dc_next;
    group_t  group_value_next;
    dcount_t digit_count_next;
    logic    last_colon_next;
    logic    in_length_next;
    logic [7:0] length_next;
    logic    error_next;

    // Result register
    logic        out_valid_reg;
    logic [63:0] upper_reg;
    logic [7:0]  length_out_reg;
    logic        bad_reg;

    logic [63:0] upper_next;
    logic [7:0]  length_out_next;
    logic        bad_next;

    logic is_newline;
    logic out_free;
    logic advance;

    assign is_newline = (char_reg == CharNewline);
    assign out_free   = !out_valid_reg || !out_stall;
    assign advance    = !in_valid_reg || !is_newline || out_free;
    assign in_stall   = !advance;

    // Per-character parse step
    always_comb
    begin
        logic       push_req;
        logic       end_req;
        logic       is_hex;
        logic [3:0] hex_val;
        logic [7:0] hex_off;
        logic [11:0] len_mul;
        logic [4:0] group_sum;

        for (int i = 0; i < HeadKeep; i++)
        begin
            head_next[i] = head_reg[i];
        end
        for (int i = 0; i < NumGroups; i++)
        begin
            tail_next[i] = tail_reg[i];
        end
        head_count_next  = head_count_reg;
        tail_count_next  = tail_count_reg;
        after_dc_next    = after_dc_reg;
        group_value_next = group_value_reg;
        digit_count_next = digit_count_reg;
        last_colon_next  = last_colon_reg;
        in_length_next   = in_length_reg;
        length_next      = length_reg;
        error_next       = error_reg;
        push_req         = 1'b0;
        end_req          = 1'b0;

        // Hex digit decode
        is_hex  = 1'b0;
        hex_val = 4'd0;
        if (char_reg inside {[CharZero:CharNine]})
        begin
            is_hex  = 1'b1;
            hex_off = char_reg - CharZero;
            hex_val = hex_off[3:0];
        end
        else if (char_reg inside {[CharLowA:CharLowF]})
        begin
            is_hex  = 1'b1;
            hex_off = char_reg - CharLowA + 8'd10;
            hex_val = hex_off[3:0];
        end
        else
        begin
            hex_off = 8'd0;
        end

        // Decimal length accumulate, saturated at 255
        len_mul = ({4'd0, length_reg} << 3) + ({4'd0, length_reg} << 1)
                  + {8'd0, hex_val};

        // Character dispatch
        if (is_newline)
        begin
            if (!in_length_reg)
            begin
                end_req    = 1'b1;
                error_next = 1'b1;
            end
            else if (digit_count_reg == 3'd0)
            begin
                error_next = 1'b1;
            end
        end
        else if (in_length_reg)
        begin
            if (char_reg inside {[CharZero:CharNine]})
            begin
                length_next      = (len_mul > 12'd255) ? 8'd255 : len_mul[7:0];
                digit_count_next = 3'd1;
            end
            else
            begin
                error_next = 1'b1;
            end
        end
        else if (is_hex)
        begin
            // lone leading colon
            if (last_colon_reg && digit_count_reg == 3'd0 &&
                head_count_reg == 4'd0 && !after_dc_reg)
            begin
                error_next = 1'b1;
            end
            last_colon_next = 1'b0;
            if (digit_count_reg >= dcount_t'(MaxDigits))
            begin
                error_next = 1'b1;
            end
            else
            begin
                group_value_next = {group_value_reg[11:0], hex_val};
                digit_count_next = digit_count_reg + 3'd1;
            end
        end
        else if (char_reg == CharColon)
        begin
            if (digit_count_reg != 3'd0)
            begin
                push_req        = 1'b1;
                last_colon_next = 1'b1;
            end
            else if (last_colon_reg)
            begin
                if (after_dc_reg)
                begin
                    error_next = 1'b1;
                end
                after_dc_next   = 1'b1;
                last_colon_next = 1'b0;
            end
            else if (head_count_reg == 4'd0 && !after_dc_reg)
            begin
                last_colon_next = 1'b1;
            end
            else
            begin
                error_next = 1'b1;
            end
        end
        else if (char_reg == CharSlash)
        begin
            end_req        = 1'b1;
            in_length_next = 1'b1;
        end
        else
        begin
            error_next = 1'b1;
        end

        // Close the open group; tail groups shift in from the top end
        if (push_req || (end_req && digit_count_reg != 3'd0))
        begin
            group_sum = {1'b0, head_count_reg} + {1'b0, tail_count_reg};
            if (group_sum >= 5'(NumGroups))
            begin
                error_next = 1'b1;
            end
            else if (after_dc_next)
            begin
                for (int i = 0; i < NumGroups - 1; i++)
                begin
                    tail_next[i] = tail_reg[i + 1];
                end
                tail_next[NumGroups - 1] = group_value_reg;
                tail_count_next = tail_count_reg + 4'd1;
            end
            else
            begin
                for (int i = 0; i < HeadKeep; i++)
                begin
                    if (head_count_reg == gcount_t'(i))
                    begin
                        head_next[i] = group_value_reg;
                    end
                end
                head_count_next = head_count_reg + 4'd1;
            end
            group_value_next = 16'd0;
            digit_count_next = 3'd0;
        end

        // Address shape checks at end of address part
        group_sum = {1'b0, head_count_next} + {1'b0, tail_count_next};
        if (end_req)
        begin
            if (last_colon_reg)
            begin
                error_next = 1'b1;
            end
            if (head_count_next == 4'd0 && !after_dc_next)
            begin
                error_next = 1'b1;
            end
            if (!after_dc_next && group_sum < 5'(NumGroups))
            begin
                error_next = 1'b1;
            end
            last_colon_next  = 1'b0;
            digit_count_next = 3'd0;
            group_value_next = 16'd0;
        end

        // Expanded upper half: head group, else right-aligned tail entry
        for (int i = 0; i < HeadKeep; i++)
        begin
            if (gcount_t'(i) < head_count_next)
            begin
                upper_next[63 - 16 * i -: 16] = head_next[i];
            end
            else
            begin
                upper_next[63 - 16 * i -: 16] = tail_next[i];
            end
        end

        // Length saturation
        bad_next        = error_next;
        length_out_next = length_reg;
        if (length_reg > 8'(MaxLen))
        begin
            bad_next        = 1'b1;
            length_out_next = 8'(MaxLen);
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            char_reg <= char_code;
        end
    end

    // Parse state; a newline returns everything to the cleared state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HeadKeep; i++)
            begin
                head_reg[i] <= '0;
            end
            for (int i = 0; i < NumGroups; i++)
            begin
                tail_reg[i] <= '0;
            end
            head_count_reg  <= '0;
            tail_count_reg  <= '0;
            after_dc_reg    <= 1'b0;
            group_value_reg <= '0;
            digit_count_reg <= '0;
            last_colon_reg  <= 1'b0;
            in_length_reg   <= 1'b0;
            length_reg      <= '0;
            error_reg       <= 1'b0;
        end
        else if (in_valid_reg && advance)
        begin
            if (is_newline)
            begin
                for (int i = 0; i < HeadKeep; i++)
                begin
                    head_reg[i] <= '0;
                end
                for (int i = 0; i < NumGroups; i++)
                begin
                    tail_reg[i] <= '0;
                end
                head_count_reg  <= '0;
                tail_count_reg  <= '0;
                after_dc_reg    <= 1'b0;
                group_value_reg <= '0;
                digit_count_reg <= '0;
                last_colon_reg  <= 1'b0;
                in_length_reg   <= 1'b0;
                length_reg      <= '0;
                error_reg       <= 1'b0;
            end
            else
            begin
                head_reg        <= head_next;
                tail_reg        <= tail_next;
                head_count_reg  <= head_count_next;
                tail_count_reg  <= tail_count_next;
                after_dc_reg    <= after_dc_next;
                group_value_reg <= group_value_next;
                digit_count_reg <= digit_count_next;
                last_colon_reg  <= last_colon_next;
                in_length_reg   <= in_length_next;
                length_reg      <= length_next;
                error_reg       <= error_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg && is_newline;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && in_valid_reg && is_newline)
        begin
            upper_reg      <= upper_next;
            length_out_reg <= length_out_next;
            bad_reg        <= bad_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign prefix_upper  = upper_reg;
    assign prefix_length = length_out_reg;
    assign malformed     = bad_reg;

endmodule
